FILE: hdl/pwpt_pkg.sv
// Shared types and constants for the winding-number point-in-polygon block.
package pwpt_pkg;

   // Operation codes carried on the request channel.
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEST   = 2'd2
   } op_type;

   localparam int OP_W      = 2;
   localparam int COORD_W   = 16;
   localparam int WINDING_W = 10;
   localparam int VCNT_W    = 9;
   localparam int AREA_W    = 41;

   // Winding number saturates into the 10-bit result field.
   localparam int WIND_MAX  = 511;
   localparam int WIND_MIN  = -512;

endpackage

FILE: hdl/pwpt_if.sv
// Request and response channel interfaces for the point-in-polygon block.
interface pwpt_req_if
   import pwpt_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [COORD_W-1:0]  x;
   logic signed [COORD_W-1:0]  y;

   modport source (output valid, operation, x, y, input ready);
   modport sink   (input valid, operation, x, y, output ready);
endinterface

interface pwpt_rsp_if
   import pwpt_pkg::*;
;
   logic                         valid;
   logic                         ready;
   logic                         inside_res;
   logic                         on_vertex;
   logic signed [WINDING_W-1:0]  winding;
   logic [VCNT_W-1:0]            vertex_count;
   logic signed [AREA_W-1:0]     area_doubled;
   logic                         store_full;

   modport source (output valid, inside_res, on_vertex, winding, vertex_count,
                   area_doubled, store_full, input ready);
   modport sink   (input valid, inside_res, on_vertex, winding, vertex_count,
                   area_doubled, store_full, output ready);
endinterface

FILE: hdl/pwpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pwpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/polygon_winding_point_test.sv
// Top level: stored polygon with shoelace area and winding-number point test.
//
// Usage:
//  - req_bus (valid/ready) carries one beat per operation: clear, append vertex
//    or test point, with x/y as signed coordinates. rsp_bus returns exactly one
//    beat per request: inside flag, on-vertex flag, winding number, vertex
//    count, doubled signed area of the closed polygon and the store-full flag.
//  - One request is worked at a time; req ready is high only while idle.
//  - Sequence after accept: clear, unused code, rejected append and test of an
//    empty polygon go straight to the closing-area step; append first computes
//    and adds its area term and writes the RAM; a test first walks the N stored
//    vertices. The test walk is bounded by the vertex RAM's single read port: one
//    edge per cycle, read through a three-stage edge pipe (difference, multiply,
//    accumulate), then the closing-edge area term on the shared multiplier pair.
//  - Results sit in an output register; a new request is taken while a result
//    still waits. If the receiver stalls, the next result is held in the final
//    step until the output register frees, and no request is taken meanwhile.
//  - Synchronous active-high reset empties the polygon (count, area and last
//    vertex zero). The vertex RAM is not cleared; entries past the count are
//    never read.
module polygon_winding_point_test
   import pwpt_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   pwpt_req_if.sink   req_bus,
   pwpt_rsp_if.source rsp_bus
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int MW = COORD_BITS + 1;
   localparam int PW = 2 * MW;
   localparam int WW = CW + 1;
   localparam int RW = (COORD_BITS > COORD_W) ? COORD_BITS : COORD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_APPEND,
      S_APPEND_ACC,
      S_WALK,
      S_DRAIN,
      S_AREA,
      S_AREA_ACC
   } state_type;

   state_type state_ff;

   // Incoming coordinates: low COORD_BITS of the raw field, zero-extended if wider, read as signed.
   logic [RW-1:0]                req_x_raw, req_y_raw;
   logic signed [COORD_BITS-1:0] req_px, req_py;

   assign req_x_raw = RW'($unsigned(req_bus.x));
   assign req_y_raw = RW'($unsigned(req_bus.y));
   assign req_px    = signed'(req_x_raw[COORD_BITS-1:0]);
   assign req_py    = signed'(req_y_raw[COORD_BITS-1:0]);

   logic req_take;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;

   // Polygon state
   logic [CW-1:0]                total_ff;
   logic signed [AREA_W-1:0]     open_area_ff;
   logic signed [COORD_BITS-1:0] last_x_ff, last_y_ff;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff;

   // Current request
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                         onv_ff, full_ff;
   logic signed [WW-1:0]         wn_ff;

   // Walk control and edge pipe
   logic [CW-1:0]                step_ff;
   logic [1:0]                   drain_ff;
   logic                         rd_v_ff, rd_first_ff, close_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic                         e_v_ff, e_up_ff, e_dn_ff;
   logic signed [MW-1:0]         e_dx_ff, e_dy_ff, e_qx_ff, e_qy_ff;
   logic                         m_v_ff, m_up_ff, m_dn_ff;
   logic signed [PW-1:0]         prod_a_ff, prod_b_ff;

   // Output register
   logic                         rsp_valid_ff;
   logic                         rsp_inside_ff, rsp_onv_ff, rsp_full_ff;
   logic signed [WINDING_W-1:0]  rsp_wind_ff;
   logic [VCNT_W-1:0]            rsp_vcnt_ff;
   logic signed [AREA_W-1:0]     rsp_area_ff;

   //------------------------------------------------------------------
   // Vertex RAM: {y, x} per entry, written on append, read on test walk
   //------------------------------------------------------------------
   logic                       ram_wr_en, ram_rd_en;
   logic [2*COORD_BITS-1:0]    ram_rd_data;
   logic signed [COORD_BITS-1:0] ram_x, ram_y;

   assign ram_wr_en = (state_ff == S_APPEND_ACC);
   assign ram_rd_en = (state_ff == S_WALK) && (step_ff < total_ff);

   pwpt_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (total_ff[AW-1:0]),
      .wr_data ({py_ff, px_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (step_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_x = signed'(ram_rd_data[COORD_BITS-1:0]);
   assign ram_y = signed'(ram_rd_data[2*COORD_BITS-1:COORD_BITS]);

   //------------------------------------------------------------------
   // Edge stage 1: pick edge end vertex (RAM or closing vertex), diffs
   //------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   logic                         edge_go, cur_hit;

   assign cur_x   = close_ff ? first_x_ff : ram_x;
   assign cur_y   = close_ff ? first_y_ff : ram_y;
   assign edge_go = close_ff || (rd_v_ff && !rd_first_ff);
   assign cur_hit = rd_v_ff && (ram_x == px_ff) && (ram_y == py_ff);

   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         prev_x_ff <= ram_x;
         prev_y_ff <= ram_y;
      end
      // edge a = prev, b = cur; k = (b - a) x (p - a)
      e_dx_ff <= MW'(cur_x) - MW'(prev_x_ff);
      e_dy_ff <= MW'(cur_y) - MW'(prev_y_ff);
      e_qx_ff <= MW'(px_ff) - MW'(prev_x_ff);
      e_qy_ff <= MW'(py_ff) - MW'(prev_y_ff);
      e_up_ff <= (prev_y_ff <= py_ff) && (cur_y > py_ff);
      e_dn_ff <= (cur_y <= py_ff) && (prev_y_ff > py_ff);
   end

   //------------------------------------------------------------------
   // Shared multiplier pair: edge cross, append cross, closing cross
   //------------------------------------------------------------------
   logic signed [MW-1:0] mul_a, mul_b, mul_c, mul_d;

   always_comb begin
      case (state_ff)
         S_APPEND, S_APPEND_ACC: begin
            mul_a = MW'(last_x_ff);
            mul_b = MW'(py_ff);
            mul_c = MW'(last_y_ff);
            mul_d = MW'(px_ff);
         end
         S_AREA, S_AREA_ACC: begin
            mul_a = MW'(last_x_ff);
            mul_b = MW'(first_y_ff);
            mul_c = MW'(last_y_ff);
            mul_d = MW'(first_x_ff);
         end
         default: begin
            mul_a = e_dx_ff;
            mul_b = e_qy_ff;
            mul_c = e_dy_ff;
            mul_d = e_qx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= mul_a * mul_b;
      prod_b_ff <= mul_c * mul_d;
      m_up_ff   <= e_up_ff;
      m_dn_ff   <= e_dn_ff;
   end

   logic signed [PW:0]       cross_diff;
   logic signed [AREA_W-1:0] cross_area;
   logic                     k_pos, k_neg;
   logic signed [WW-1:0]     wn_delta;

   assign cross_diff = (PW + 1)'(prod_a_ff) - (PW + 1)'(prod_b_ff);
   assign cross_area = AREA_W'(cross_diff);
   assign k_neg      = cross_diff[PW];
   assign k_pos      = !cross_diff[PW] && (cross_diff != '0);

   always_comb begin
      if (m_up_ff && k_pos) begin
         wn_delta = WW'(1);
      end else if (m_dn_ff && k_neg) begin
         wn_delta = -WW'(1);
      end else begin
         wn_delta = '0;
      end
   end

   //------------------------------------------------------------------
   // Result formatting
   //------------------------------------------------------------------
   logic signed [WINDING_W-1:0] wind_sat;
   logic signed [AREA_W-1:0]    closed_area;

   always_comb begin
      if (onv_ff) begin
         wind_sat = '0;
      end else if (wn_ff > WIND_MAX) begin
         wind_sat = WINDING_W'(WIND_MAX);
      end else if (wn_ff < WIND_MIN) begin
         wind_sat = WINDING_W'(WIND_MIN);
      end else begin
         wind_sat = WINDING_W'(wn_ff);
      end
   end

   assign closed_area = (total_ff == '0) ? '0 : open_area_ff + cross_area;

   //------------------------------------------------------------------
   // Sequencer and control state
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         open_area_ff <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         step_ff      <= '0;
         drain_ff     <= '0;
         rd_v_ff      <= 1'b0;
         rd_first_ff  <= 1'b0;
         close_ff     <= 1'b0;
         e_v_ff       <= 1'b0;
         m_v_ff       <= 1'b0;
         onv_ff       <= 1'b0;
         full_ff      <= 1'b0;
         wn_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff     <= ram_rd_en;
         rd_first_ff <= (step_ff == '0);
         close_ff    <= (state_ff == S_WALK) && (step_ff == total_ff);
         e_v_ff      <= edge_go;
         m_v_ff      <= e_v_ff;
         if (cur_hit) begin
            onv_ff <= 1'b1;
         end
         if (m_v_ff) begin
            wn_ff <= wn_ff + wn_delta;
         end
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  px_ff    <= req_px;
                  py_ff    <= req_py;
                  onv_ff   <= 1'b0;
                  full_ff  <= 1'b0;
                  wn_ff    <= '0;
                  step_ff  <= '0;
                  state_ff <= S_AREA;
                  case (op_type'(req_bus.operation))
                     OP_CLEAR: begin
                        total_ff     <= '0;
                        open_area_ff <= '0;
                        last_x_ff    <= '0;
                        last_y_ff    <= '0;
                     end
                     OP_APPEND: begin
                        if (total_ff == CW'(MAX_VERTICES)) begin
                           full_ff <= 1'b1;
                        end else begin
                           state_ff <= S_APPEND;
                        end
                     end
                     OP_TEST: begin
                        if (total_ff != '0) begin
                           state_ff <= S_WALK;
                        end
                     end
                     default: begin
                        state_ff <= S_AREA;
                     end
                  endcase
               end
            end
            S_APPEND: begin
               state_ff <= S_APPEND_ACC;
            end
            S_APPEND_ACC: begin
               // RAM write of {py, px} at total happens this cycle
               if (total_ff != '0) begin
                  open_area_ff <= open_area_ff + cross_area;
               end else begin
                  first_x_ff <= px_ff;
                  first_y_ff <= py_ff;
               end
               last_x_ff <= px_ff;
               last_y_ff <= py_ff;
               total_ff  <= total_ff + CW'(1);
               state_ff  <= S_AREA;
            end
            S_WALK: begin
               // one read per cycle, then a final step for the closing edge
               step_ff <= step_ff + CW'(1);
               if (step_ff == total_ff) begin
                  drain_ff <= '0;
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               // let the last edge pass difference, multiply and accumulate
               drain_ff <= drain_ff + 2'd1;
               if (drain_ff == 2'd2) begin
                  state_ff <= S_AREA;
               end
            end
            S_AREA: begin
               state_ff <= S_AREA_ACC;
            end
            S_AREA_ACC: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= !onv_ff && (wn_ff != '0);
                  rsp_onv_ff    <= onv_ff;
                  rsp_wind_ff   <= wind_sat;
                  rsp_vcnt_ff   <= VCNT_W'(total_ff);
                  rsp_area_ff   <= closed_area;
                  rsp_full_ff   <= full_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.inside_res   = rsp_inside_ff;
   assign rsp_bus.on_vertex    = rsp_onv_ff;
   assign rsp_bus.winding      = rsp_wind_ff;
   assign rsp_bus.vertex_count = rsp_vcnt_ff;
   assign rsp_bus.area_doubled = rsp_area_ff;
   assign rsp_bus.store_full   = rsp_full_ff;

endmodule
